/* design/lzos_pkg.sv */
// Shared types and constants for the layer z-order stack.
`timescale 1ns / 1ps

package lzos_pkg;

    localparam int LAYER_W = 8;
    localparam int HGT_W   = 9;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    localparam logic signed [HGT_W-1:0] HGT_NONE = -9'sd1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // Broadcast to every slot cell: a shift over slots lo..hi, plus one load.
    typedef struct packed {
        logic                      active;
        logic                      from_below;
        logic signed [HGT_W:0]     lo;
        logic signed [HGT_W:0]     hi;
        logic                      load;
        logic signed [HGT_W:0]     load_idx;
        logic [LAYER_W-1:0]        load_layer;
    } shift_ctrl_t;

endpackage

/* design/layer_z_order_stack.sv */
// Layer z-order stack: a pool of display layers and their stacking order.
// Input words on s_t* carry a command (allocate, set height, free), a layer
// index and a requested height; each gives exactly one result word on m_t*
// with the layer, an ok flag, the applied height, the new top height and a
// redraw flag. The stacking order lives in a row of slot cells, one per
// height, which shift towards their neighbours together when a layer moves.
// A word is taken in the idle cycle; in that cycle the slot cells compare
// the layer against their contents and the free map is searched per group
// of sixteen. The execute cycle decodes the old height, clamps the request,
// shifts every affected cell at once and loads the result register.
// m_tvalid rises at the edge that ends the execute cycle; a new word is taken
// only once the last one has left execute, as the cell row compares, then shifts.
// If m_tready is low while a result waits, the next word is still taken;
// its execute cycle then holds until the waiting result leaves.
// Reset releases every layer, sets top to -1 and empties the result
// register; the slot contents need no clearing as only live slots are read.
`timescale 1ns / 1ps

module layer_z_order_stack import lzos_pkg::*; #(
    parameter int MAX_LAYERS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // command[1:0], layer[9:2], height[18:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // layer_out[7:0], ok[8], applied_height[17:9],
                                   // top_out[26:18], redraw[27]
);

    localparam int POOL = (MAX_LAYERS < 256) ? MAX_LAYERS : 256;
    localparam int IW   = (POOL > 1) ? $clog2(POOL) : 1;

    state_t                   state_reg, state_next;
    logic signed [HGT_W-1:0]  top_reg, top_next;
    logic                     m_valid_reg, m_valid_next;

    logic [CMD_W-1:0]         cmd_reg;
    logic [LAYER_W-1:0]       lay_reg;
    logic signed [HGT_W-1:0]  hgt_reg;
    logic                     valid_reg;
    logic [POOL-1:0]          match_reg;

    logic [LAYER_W-1:0]       lay_out_reg;
    logic                     ok_reg;
    logic signed [HGT_W-1:0]  applied_reg;
    logic signed [HGT_W-1:0]  top_out_reg;
    logic                     redraw_reg;

    logic [CMD_W-1:0]         in_cmd;
    logic [LAYER_W-1:0]       in_layer;
    logic signed [HGT_W-1:0]  in_hgt;
    logic                     accept;
    logic                     commit;
    logic                     used;
    logic                     found;
    logic [LAYER_W-1:0]       found_idx;

    logic [LAYER_W-1:0]       slot_w  [POOL];
    logic [LAYER_W-1:0]       below_w [POOL];
    logic [LAYER_W-1:0]       above_w [POOL];
    logic [POOL-1:0]          match_w;
    shift_ctrl_t              ctrl;

    logic [IW-1:0]            enc;
    logic                     shown;
    logic signed [HGT_W:0]    old_h, top_ext, want_ext, lim, clamp_hi, w_set, tgt;
    logic                     is_alloc, is_set, is_free;
    logic                     moving, go_down, go_up, hide, show;

    logic [LAYER_W-1:0]       lay_out_next;
    logic                     ok_next;
    logic signed [HGT_W-1:0]  applied_next;
    logic                     redraw_next;

    assign in_cmd   = s_tdata[1:0];
    assign in_layer = s_tdata[9:2];
    assign in_hgt   = s_tdata[18:10];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    // slot cells
    for (genvar h = 0; h < POOL; h++) begin : g_cell
        if (h == 0) begin : g_first
            assign below_w[h] = '0;
        end else begin : g_below
            assign below_w[h] = slot_w[h-1];
        end
        if (h == POOL - 1) begin : g_last
            assign above_w[h] = '0;
        end else begin : g_above
            assign above_w[h] = slot_w[h+1];
        end

        lzos_cell #(.IDX(h)) u_cell (
            .aclk  (aclk),
            .ctrl  (ctrl),
            .below (below_w[h]),
            .above (above_w[h]),
            .key   (in_layer),
            .top   (top_reg),
            .slot  (slot_w[h]),
            .match (match_w[h])
        );
    end

    lzos_alloc #(.POOL(POOL)) u_alloc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lookup    (in_layer),
        .used      (used),
        .cap       (accept),
        .found     (found),
        .found_idx (found_idx),
        .set_en    (commit && is_alloc && found),
        .clr_en    (commit && is_free),
        .clr_idx   (lay_reg)
    );

    // old height: position of the single matching live slot, else hidden
    always_comb begin
        enc = '0;
        for (int h = 0; h < POOL; h++) begin
            if (match_reg[h]) begin
                enc = enc | IW'(h);
            end
        end
    end

    assign shown    = |match_reg;
    assign old_h    = shown ? (HGT_W+1)'(enc) : -10'sd1;
    assign top_ext  = {top_reg[HGT_W-1], top_reg};
    assign want_ext = {hgt_reg[HGT_W-1], hgt_reg};
    assign lim      = shown ? top_ext : top_ext + 10'sd1;
    assign clamp_hi = (want_ext > lim) ? lim : want_ext;
    assign w_set    = (clamp_hi < -10'sd1) ? -10'sd1 : clamp_hi;

    assign is_alloc = (cmd_reg == CMD_ALLOC);
    assign is_set   = (cmd_reg == CMD_SET) && valid_reg;
    assign is_free  = (cmd_reg == CMD_FREE) && valid_reg;

    assign tgt      = is_free ? -10'sd1 : w_set;
    assign moving   = (is_set || is_free) && (tgt != old_h);
    assign go_down  = moving && (tgt < old_h);
    assign go_up    = moving && (tgt > old_h);
    assign hide     = go_down && (tgt == -10'sd1);
    assign show     = go_up && !shown;

    always_comb begin
        ctrl            = '0;
        ctrl.active     = commit && moving;
        ctrl.load       = !hide;
        ctrl.load_idx   = tgt;
        ctrl.load_layer = lay_reg;
        if (go_down && !hide) begin
            ctrl.from_below = 1'b1;
            ctrl.lo         = tgt + 10'sd1;
            ctrl.hi         = old_h;
        end else if (show) begin
            ctrl.from_below = 1'b1;
            ctrl.lo         = tgt + 10'sd1;
            ctrl.hi         = top_ext + 10'sd1;
        end else if (hide) begin
            ctrl.lo = old_h;
            ctrl.hi = top_ext - 10'sd1;
        end else begin
            ctrl.lo = old_h;
            ctrl.hi = tgt - 10'sd1;
        end
    end

    always_comb begin
        top_next = top_reg;
        if (commit && hide) begin
            top_next = top_reg - 9'sd1;
        end else if (commit && show) begin
            top_next = top_reg + 9'sd1;
        end
    end

    always_comb begin
        lay_out_next = lay_reg;
        ok_next      = is_set || is_free;
        applied_next = HGT_NONE;
        redraw_next  = 1'b0;
        if (is_alloc) begin
            lay_out_next = found ? found_idx : '0;
            ok_next      = found;
        end else if (is_set) begin
            applied_next = w_set[HGT_W-1:0];
            redraw_next  = (w_set != old_h);
        end else if (is_free) begin
            redraw_next = shown;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // hold the result while the receiver stalls
    assign m_valid_next = commit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            top_reg     <= HGT_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= in_cmd;
            lay_reg   <= in_layer;
            hgt_reg   <= in_hgt;
            valid_reg <= used;
            match_reg <= match_w;
        end
        if (commit) begin
            lay_out_reg <= lay_out_next;
            ok_reg      <= ok_next;
            applied_reg <= applied_next;
            top_out_reg <= top_next;
            redraw_reg  <= redraw_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, redraw_reg, top_out_reg, applied_reg, ok_reg, lay_out_reg};

`ifndef SYNTHESIS
    a_single_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> $onehot0(match_reg))
        else $error("layer found in more than one live slot");
    a_shown_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EXEC) && (|match_reg)) |-> valid_reg)
        else $error("shown layer is not in use");
    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (m_tvalid && (state_reg == ST_IDLE)))
        else $error("result lost after execute");
    a_top_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg >= HGT_NONE)
        else $error("top height below hidden");
`endif

endmodule

/* design/lzos_cell.sv */
// One stack slot: holds the layer at its height and shifts with its neighbours.
`timescale 1ns / 1ps

module lzos_cell import lzos_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                      aclk,
    input  shift_ctrl_t               ctrl,
    input  logic [LAYER_W-1:0]        below,
    input  logic [LAYER_W-1:0]        above,
    input  logic [LAYER_W-1:0]        key,
    input  logic signed [HGT_W-1:0]   top,
    output logic [LAYER_W-1:0]        slot,
    output logic                      match
);

    localparam logic signed [HGT_W:0] POS = (HGT_W+1)'(IDX);

    logic [LAYER_W-1:0]      slot_reg;
    logic [LAYER_W-1:0]      slot_next;
    logic signed [HGT_W:0]   top_ext;

    assign top_ext = {top[HGT_W-1], top};

    always_comb begin
        slot_next = slot_reg;
        if (ctrl.active) begin
            if (ctrl.load && (ctrl.load_idx == POS)) begin
                slot_next = ctrl.load_layer;
            end else if ((POS >= ctrl.lo) && (POS <= ctrl.hi)) begin
                slot_next = ctrl.from_below ? below : above;
            end
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    // only slots up to top hold live layers
    assign match = (slot_reg == key) && (POS <= top_ext);
    assign slot  = slot_reg;

endmodule

/* design/lzos_alloc.sv */
// In-use map of the layer pool and the two-level lowest-free-layer search.
`timescale 1ns / 1ps

module lzos_alloc import lzos_pkg::*; #(
    parameter int POOL = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [LAYER_W-1:0]   lookup,
    output logic                 used,
    input  logic                 cap,
    output logic                 found,
    output logic [LAYER_W-1:0]   found_idx,
    input  logic                 set_en,
    input  logic                 clr_en,
    input  logic [LAYER_W-1:0]   clr_idx
);

    localparam int IW = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int GW = 16;
    localparam int LW = $clog2(GW);
    localparam int NG = (POOL + GW - 1) / GW;

    logic [POOL-1:0]    in_use_reg;
    logic [POOL-1:0]    in_use_next;
    logic [NG*GW-1:0]   padded;
    logic [NG-1:0]      grp_free_next;
    logic [NG-1:0]      grp_free_reg;
    logic [LW-1:0]      grp_loc_next [NG];
    logic [LW-1:0]      grp_loc_reg  [NG];

    assign used = ({1'b0, lookup} < (LAYER_W+1)'(POOL)) && in_use_reg[lookup[IW-1:0]];

    // padding beyond the pool counts as taken
    always_comb begin
        for (int i = 0; i < NG*GW; i++) begin
            padded[i] = (i < POOL) ? in_use_reg[i] : 1'b1;
        end
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_free_next[g] = 1'b0;
            grp_loc_next[g]  = '0;
            for (int j = GW - 1; j >= 0; j--) begin
                if (!padded[g*GW + j]) begin
                    grp_free_next[g] = 1'b1;
                    grp_loc_next[g]  = LW'(j);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_free_reg <= '0;
        end else if (cap) begin
            grp_free_reg <= grp_free_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cap) begin
            grp_loc_reg <= grp_loc_next;
        end
    end

    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (grp_free_reg[g]) begin
                found     = 1'b1;
                found_idx = LAYER_W'(g*GW + int'(grp_loc_reg[g]));
            end
        end
    end

    always_comb begin
        in_use_next = in_use_reg;
        if (set_en) begin
            in_use_next[found_idx[IW-1:0]] = 1'b1;
        end
        if (clr_en) begin
            in_use_next[clr_idx[IW-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else begin
            in_use_reg <= in_use_next;
        end
    end

`ifndef SYNTHESIS
    a_alloc_free: assert property (@(posedge aclk) disable iff (!aresetn)
        set_en |-> !in_use_reg[found_idx[IW-1:0]])
        else $error("allocating a layer already in use");
    a_free_used: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_en |-> in_use_reg[clr_idx[IW-1:0]])
        else $error("releasing a layer not in use");
    a_one_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !(set_en && clr_en))
        else $error("allocate and free in one cycle");
`endif

endmodule
